FILE: design/um_pkg.sv
package um_pkg;

   localparam int TICK_W     = 32;
   localparam int WIN_W      = 16;
   localparam int PCT_W      = 7;
   localparam int MARGIN_W   = 7;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   // act * 100 needs seven more bits than act
   localparam int DIVIDEND_W = TICK_W + PCT_W;
   localparam int LIMIT_W    = WIN_W + PCT_W;

   localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;
   localparam logic [PCT_W-1:0]   PCT_SAT   = 7'd101;

   localparam logic [WIN_W-1:0]    MIN_WINDOW_RST  = 16'd30;
   localparam logic [WIN_W-1:0]    MAX_WINDOW_RST  = 16'd60;
   localparam logic [MARGIN_W-1:0] PEAK_MARGIN_RST = 7'd3;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WINDOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WINDOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_MARGIN = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_PRIMED    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_SHORT = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RESTART   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_MEASURED  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED   = 3'd4;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

endpackage

FILE: design/um_div.sv
module um_div
   import um_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [WIN_W-1:0]      divisor,
   output logic                  done,
   output logic [PCT_W-1:0]      quotient
);

   // restoring divider, one quotient bit per cycle; needs dividend < divisor * 128
   localparam int DSH_W = WIN_W + PCT_W - 1;
   localparam int CNT_W = $clog2(PCT_W);

   logic [DIVIDEND_W-1:0] rem_ff;
   logic [DSH_W-1:0]      dsh_ff;
   logic [PCT_W-1:0]      quo_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVIDEND_W-1:0] dsh_ext;
   logic                  fits;

   assign dsh_ext  = DIVIDEND_W'(dsh_ff);
   assign fits     = rem_ff >= dsh_ext;
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         dsh_ff  <= '0;
         quo_ff  <= '0;
      end else begin
         if (start) begin
            rem_ff  <= dividend;
            dsh_ff  <= {divisor, (PCT_W-1)'(0)};
            quo_ff  <= '0;
            cnt_ff  <= CNT_W'(PCT_W-1);
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= rem_ff - dsh_ext;
            end
            quo_ff  <= {quo_ff[PCT_W-2:0], fits};
            dsh_ff  <= dsh_ff >> 1;
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == '0);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: design/utilization_meter_unit.sv
// Sequence: a clear or a priming sample is decided in S_DIFF, a too-short or restarting
// sample in S_CLASS; a measured sample runs S_SCALE and S_SAT, then the shared restoring
// divider for the percentage (skipped when it saturates), S_HIST, S_AVG, the divider again
// for the average, and S_PEAK. Flow: one request at a time; the next is taken the cycle
// after the response is loaded in S_DONE, later while a held response blocks it.
// Reset: synchronous, active high; statistics zero, registers to 30, 60 and 3.
module utilization_meter_unit
   import um_pkg::*;
#(
   parameter int HISTORY_DEPTH = 10
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [TICK_W-1:0]     req_now_tick,
   input  logic [TICK_W-1:0]     req_total_active,
   input  logic [TICK_W-1:0]     req_self_active,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [PCT_W-1:0]      rsp_instant_percent,
   output logic [PCT_W-1:0]      rsp_smoothed_percent,
   output logic [PCT_W-1:0]      rsp_peak_percent,
   output logic [TICK_W-1:0]     rsp_active_delta,
   output logic [WIN_W-1:0]      rsp_window_delta,
   output logic                  rsp_primed,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = $clog2(HISTORY_DEPTH * 100 + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DIFF, S_CLASS, S_SCALE, S_SAT, S_DIV_PCT,
      S_HIST, S_AVG, S_DIV_AVG, S_PEAK, S_DONE
   } state_type;

   state_type state_ff;

   logic [WIN_W-1:0]    min_window_ff;
   logic [WIN_W-1:0]    max_window_ff;
   logic [MARGIN_W-1:0] peak_margin_ff;

   logic                in_type_ff;
   logic [TICK_W-1:0]   in_now_ff;
   logic [TICK_W-1:0]   in_total_ff;
   logic [TICK_W-1:0]   in_self_ff;

   logic [TICK_W-1:0]   base_tick_ff;
   logic [TICK_W-1:0]   base_total_ff;
   logic [TICK_W-1:0]   base_self_ff;
   logic                have_base_ff;
   logic [PCT_W-1:0]    instant_ff;
   logic [PCT_W-1:0]    smoothed_ff;
   logic [PCT_W-1:0]    peak_ff;
   logic [PTR_W-1:0]    ptr_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [TICK_W-1:0]   last_active_ff;
   logic [WIN_W-1:0]    last_window_ff;
   logic [STATUS_W-1:0] status_ff;

   logic                back_ff;
   logic                tot_dec_ff;
   logic                self_dec_ff;
   logic [TICK_W-1:0]   win_ff;
   logic [TICK_W-1:0]   dtot_ff;
   logic [TICK_W-1:0]   dself_ff;
   logic [TICK_W-1:0]   act_ff;
   logic [DIVIDEND_W-1:0] prod_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [PCT_W-1:0]    old_ff;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [PCT_W-1:0]      rsp_instant_ff;
   logic [PCT_W-1:0]      rsp_smoothed_ff;
   logic [PCT_W-1:0]      rsp_peak_ff;
   logic [TICK_W-1:0]     rsp_active_ff;
   logic [WIN_W-1:0]      rsp_window_ff;
   logic                  rsp_primed_ff;

   logic [PCT_W-1:0] ring_mem [HISTORY_DEPTH];
   logic             ring_we;

   div_ctl_type           div_ctl;
   logic                  div_start_ff;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [WIN_W-1:0]      div_divisor;
   logic [PCT_W-1:0]      div_quotient;

   logic [TICK_W:0]   win_full;
   logic [TICK_W:0]   dtot_full;
   logic [TICK_W:0]   dself_full;
   logic              ring_full;
   logic [SUM_W-1:0]  sum_next;
   logic [PCT_W:0]    peak_limit;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_instant_percent  = rsp_instant_ff;
   assign rsp_smoothed_percent = rsp_smoothed_ff;
   assign rsp_peak_percent     = rsp_peak_ff;
   assign rsp_active_delta     = rsp_active_ff;
   assign rsp_window_delta     = rsp_window_ff;
   assign rsp_primed           = rsp_primed_ff;

   assign win_full   = {1'b0, in_now_ff}   - {1'b0, base_tick_ff};
   assign dtot_full  = {1'b0, in_total_ff} - {1'b0, base_total_ff};
   assign dself_full = {1'b0, in_self_ff}  - {1'b0, base_self_ff};

   assign ring_full  = (fill_ff == FILL_W'(HISTORY_DEPTH));
   assign sum_next   = sum_ff + SUM_W'(instant_ff) - (ring_full ? SUM_W'(old_ff) : '0);
   assign peak_limit = {1'b0, smoothed_ff} + {1'b0, peak_margin_ff};
   assign ring_we    = (state_ff == S_HIST);

   assign div_ctl = '{start: div_start_ff, done: div_done};

   always_comb begin
      if (state_ff == S_DIV_AVG) begin
         div_dividend = DIVIDEND_W'(sum_ff);
         div_divisor  = WIN_W'(fill_ff);
      end else begin
         div_dividend = prod_ff;
         div_divisor  = win_ff[WIN_W-1:0];
      end
   end

   um_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_ctl.start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ptr_ff] <= instant_ff;
      end
      if (state_ff == S_CLASS) begin
         old_ff <= ring_mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_window_ff <= MIN_WINDOW_RST;
         max_window_ff <= MAX_WINDOW_RST;
         peak_margin_ff <= PEAK_MARGIN_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_WINDOW:  min_window_ff  <= csr_data;
            CSR_MAX_WINDOW:  max_window_ff  <= csr_data;
            CSR_PEAK_MARGIN: peak_margin_ff <= csr_data[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         in_type_ff      <= REQ_SAMPLE;
         in_now_ff       <= '0;
         in_total_ff     <= '0;
         in_self_ff      <= '0;
         base_tick_ff    <= '0;
         base_total_ff   <= '0;
         base_self_ff    <= '0;
         have_base_ff    <= 1'b0;
         instant_ff      <= '0;
         smoothed_ff     <= '0;
         peak_ff         <= '0;
         ptr_ff          <= '0;
         fill_ff         <= '0;
         sum_ff          <= '0;
         last_active_ff  <= '0;
         last_window_ff  <= '0;
         status_ff       <= STATUS_PRIMED;
         back_ff         <= 1'b0;
         tot_dec_ff      <= 1'b0;
         self_dec_ff     <= 1'b0;
         win_ff          <= '0;
         dtot_ff         <= '0;
         dself_ff        <= '0;
         act_ff          <= '0;
         prod_ff         <= '0;
         limit_ff        <= '0;
         div_start_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_status_ff   <= STATUS_PRIMED;
         rsp_instant_ff  <= '0;
         rsp_smoothed_ff <= '0;
         rsp_peak_ff     <= '0;
         rsp_active_ff   <= '0;
         rsp_window_ff   <= '0;
         rsp_primed_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  in_type_ff  <= req_type;
                  in_now_ff   <= req_now_tick;
                  in_total_ff <= req_total_active;
                  in_self_ff  <= req_self_active;
                  state_ff    <= S_DIFF;
               end
            end

            S_DIFF: begin
               if (in_type_ff == REQ_CLEAR) begin
                  base_tick_ff   <= '0;
                  base_total_ff  <= '0;
                  base_self_ff   <= '0;
                  have_base_ff   <= 1'b0;
                  instant_ff     <= '0;
                  smoothed_ff    <= '0;
                  peak_ff        <= '0;
                  ptr_ff         <= '0;
                  fill_ff        <= '0;
                  sum_ff         <= '0;
                  last_active_ff <= '0;
                  last_window_ff <= '0;
                  status_ff      <= STATUS_CLEARED;
                  state_ff       <= S_DONE;
               end else if (!have_base_ff) begin
                  base_tick_ff  <= in_now_ff;
                  base_total_ff <= in_total_ff;
                  base_self_ff  <= in_self_ff;
                  have_base_ff  <= 1'b1;
                  status_ff     <= STATUS_PRIMED;
                  state_ff      <= S_DONE;
               end else begin
                  back_ff     <= win_full[TICK_W];
                  win_ff      <= win_full[TICK_W-1:0];
                  tot_dec_ff  <= dtot_full[TICK_W];
                  dtot_ff     <= dtot_full[TICK_W-1:0];
                  self_dec_ff <= dself_full[TICK_W];
                  dself_ff    <= dself_full[TICK_W-1:0];
                  state_ff    <= S_CLASS;
               end
            end

            S_CLASS: begin
               if (back_ff) begin
                  base_tick_ff  <= in_now_ff;
                  base_total_ff <= in_total_ff;
                  base_self_ff  <= in_self_ff;
                  status_ff     <= STATUS_RESTART;
                  state_ff      <= S_DONE;
               end else if (win_ff == '0 || win_ff < TICK_W'(min_window_ff)) begin
                  status_ff <= STATUS_TOO_SHORT;
                  state_ff  <= S_DONE;
               end else if (win_ff > TICK_W'(max_window_ff) || tot_dec_ff || self_dec_ff
                            || dtot_ff < dself_ff) begin
                  base_tick_ff  <= in_now_ff;
                  base_total_ff <= in_total_ff;
                  base_self_ff  <= in_self_ff;
                  status_ff     <= STATUS_RESTART;
                  state_ff      <= S_DONE;
               end else begin
                  act_ff   <= dtot_ff - dself_ff;
                  state_ff <= S_SCALE;
               end
            end

            S_SCALE: begin
               // act * 100 = act * 64 + act * 32 + act * 4
               prod_ff  <= DIVIDEND_W'({act_ff, 6'b0}) + DIVIDEND_W'({act_ff, 5'b0})
                           + DIVIDEND_W'({act_ff, 2'b0});
               limit_ff <= LIMIT_W'(win_ff[WIN_W-1:0]) * LIMIT_W'(PCT_SAT);
               state_ff <= S_SAT;
            end

            S_SAT: begin
               if (prod_ff >= DIVIDEND_W'(limit_ff)) begin
                  instant_ff <= PCT_FULL;
                  state_ff   <= S_HIST;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_PCT;
               end
            end

            S_DIV_PCT: begin
               div_start_ff <= 1'b0;
               if (div_ctl.done) begin
                  instant_ff <= div_quotient;
                  state_ff   <= S_HIST;
               end
            end

            S_HIST: begin
               sum_ff <= sum_next;
               if (!ring_full) begin
                  fill_ff <= fill_ff + 1'b1;
               end
               if (ptr_ff == PTR_W'(HISTORY_DEPTH - 1)) begin
                  ptr_ff <= '0;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
               end
               last_active_ff <= act_ff;
               last_window_ff <= win_ff[WIN_W-1:0];
               base_tick_ff   <= in_now_ff;
               base_total_ff  <= in_total_ff;
               base_self_ff   <= in_self_ff;
               state_ff       <= S_AVG;
            end

            S_AVG: begin
               div_start_ff <= 1'b1;
               state_ff     <= S_DIV_AVG;
            end

            S_DIV_AVG: begin
               div_start_ff <= 1'b0;
               if (div_ctl.done) begin
                  smoothed_ff <= div_quotient;
                  state_ff    <= S_PEAK;
               end
            end

            S_PEAK: begin
               if (instant_ff > peak_ff) begin
                  peak_ff <= instant_ff;
               end else if ({1'b0, peak_ff} > peak_limit) begin
                  peak_ff <= peak_ff - 1'b1;
               end
               status_ff <= STATUS_MEASURED;
               state_ff  <= S_DONE;
            end

            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= status_ff;
                  rsp_instant_ff  <= instant_ff;
                  rsp_smoothed_ff <= smoothed_ff;
                  rsp_peak_ff     <= peak_ff;
                  rsp_active_ff   <= last_active_ff;
                  rsp_window_ff   <= last_window_ff;
                  rsp_primed_ff   <= have_base_ff;
                  state_ff        <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: design/um_checker.sv
module um_checker
   import um_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [PCT_W-1:0]      rsp_instant_percent,
   input logic [PCT_W-1:0]      rsp_smoothed_percent,
   input logic [PCT_W-1:0]      rsp_peak_percent,
   input logic [TICK_W-1:0]     rsp_active_delta,
   input logic [WIN_W-1:0]      rsp_window_delta,
   input logic                  rsp_primed
);

   // one request in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_cleared_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_CLEARED |->
         !rsp_primed && rsp_instant_percent == '0 && rsp_smoothed_percent == '0 &&
         rsp_peak_percent == '0 && rsp_active_delta == '0 && rsp_window_delta == '0)
      else $error("clear response carries stale statistics");

   a_measured: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_MEASURED |->
         rsp_primed && rsp_window_delta != '0 && rsp_instant_percent <= PCT_FULL &&
         rsp_smoothed_percent <= PCT_FULL)
      else $error("measured response inconsistent");

   a_primed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_PRIMED |-> rsp_primed)
      else $error("primed response without baseline");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_active_delta))
      else $error("stalled response changed");

endmodule

bind utilization_meter_unit um_checker u_um_checker (.*);

FILE: dv/tb_utilization_meter_unit.sv
`timescale 1ns / 1ps

module tb_utilization_meter_unit;
   import um_pkg::*;

   localparam int HIST_DEPTH  = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 144;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic              kind;
      logic [TICK_W-1:0] now;
      logic [TICK_W-1:0] total;
      logic [TICK_W-1:0] own;
   } sample_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PCT_W-1:0]    instant;
      logic [PCT_W-1:0]    smoothed;
      logic [PCT_W-1:0]    peak;
      logic [TICK_W-1:0]   active;
      logic [WIN_W-1:0]    window;
      logic                primed;
   } meter_reading_type;

   typedef struct {
      bit                    is_cfg;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      sample_req_type        smp;
      bit                    typed;
      meter_reading_type     want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_type;
   logic [TICK_W-1:0]     req_now_tick;
   logic [TICK_W-1:0]     req_total_active;
   logic [TICK_W-1:0]     req_self_active;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [STATUS_W-1:0]   rsp_status;
   logic [PCT_W-1:0]      rsp_instant_percent;
   logic [PCT_W-1:0]      rsp_smoothed_percent;
   logic [PCT_W-1:0]      rsp_peak_percent;
   logic [TICK_W-1:0]     rsp_active_delta;
   logic [WIN_W-1:0]      rsp_window_delta;
   logic                  rsp_primed;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // predictor state
   logic [TICK_W-1:0]   cfg_min, cfg_max;
   logic [MARGIN_W-1:0] cfg_margin;
   logic [TICK_W-1:0]   base_tick, base_total, base_own;
   logic                have_base;
   logic [PCT_W-1:0]    inst_pct, smooth_pct, peak_pct;
   logic [PCT_W-1:0]    history [HIST_DEPTH];
   int                  hist_ptr, hist_fill;
   logic [TICK_W-1:0]   last_active;
   logic [WIN_W-1:0]    last_window;

   meter_reading_type expected_readings[$];
   bit             calm = 1'b0;
   int             mismatches = 0;
   int             rsp_count = 0;
   int             cycle_count = 0;

   utilization_meter_unit #(.HISTORY_DEPTH(HIST_DEPTH)) DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_now_tick         (req_now_tick),
      .req_total_active     (req_total_active),
      .req_self_active      (req_self_active),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_instant_percent  (rsp_instant_percent),
      .rsp_smoothed_percent (rsp_smoothed_percent),
      .rsp_peak_percent     (rsp_peak_percent),
      .rsp_active_delta     (rsp_active_delta),
      .rsp_window_delta     (rsp_window_delta),
      .rsp_primed           (rsp_primed),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   function automatic void clear_stats();
      base_tick   = '0;
      base_total  = '0;
      base_own    = '0;
      have_base   = 1'b0;
      inst_pct    = '0;
      smooth_pct  = '0;
      peak_pct    = '0;
      for (int i = 0; i < HIST_DEPTH; i++) history[i] = '0;
      hist_ptr    = 0;
      hist_fill   = 0;
      last_active = '0;
      last_window = '0;
   endfunction

   function automatic void rebase(sample_req_type r);
      base_tick  = r.now;
      base_total = r.total;
      base_own   = r.own;
   endfunction

   function automatic meter_reading_type predict_reading(sample_req_type r);
      meter_reading_type o;
      logic [TICK_W-1:0] span, act;
      logic [63:0] pct;
      int sum;
      if (r.kind == REQ_CLEAR) begin
         clear_stats();
         o.status = STATUS_CLEARED;
      end else if (!have_base) begin
         rebase(r);
         have_base = 1'b1;
         o.status = STATUS_PRIMED;
      end else if (r.now < base_tick) begin
         rebase(r);
         o.status = STATUS_RESTART;
      end else begin
         span = r.now - base_tick;
         if (span == 0 || span < cfg_min) begin
            o.status = STATUS_TOO_SHORT;
         end else if (span > cfg_max || r.total < base_total || r.own < base_own ||
                      (r.total - base_total) < (r.own - base_own)) begin
            rebase(r);
            o.status = STATUS_RESTART;
         end else begin
            act = (r.total - base_total) - (r.own - base_own);
            pct = (64'(act) * 64'd100) / 64'(span);
            if (pct > 64'd100) pct = 64'd100;
            last_active = act;
            last_window = span[WIN_W-1:0];
            inst_pct = pct[PCT_W-1:0];
            history[hist_ptr] = inst_pct;
            hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
            if (hist_fill < HIST_DEPTH) hist_fill++;
            sum = 0;
            for (int i = 0; i < hist_fill; i++) sum += int'(history[i]);
            smooth_pct = PCT_W'(sum / hist_fill);
            if (inst_pct > peak_pct) begin
               peak_pct = inst_pct;
            end else if (int'(peak_pct) > int'(smooth_pct) + int'(cfg_margin)) begin
               peak_pct = peak_pct - 1'b1;
            end
            rebase(r);
            o.status = STATUS_MEASURED;
         end
      end
      o.instant  = inst_pct;
      o.smoothed = smooth_pct;
      o.peak     = peak_pct;
      o.active   = last_active;
      o.window   = last_window;
      o.primed   = have_base;
      return o;
   endfunction

   // mostly well-formed samples built on the current baseline, some faults and noise
   function automatic sample_req_type make_sample();
      sample_req_type r;
      int pick, lo, hi, span;
      logic [TICK_W-1:0] act_d, own_d;
      pick    = $urandom_range(0, 99);
      r.kind  = REQ_SAMPLE;
      r.now   = $urandom;
      r.total = $urandom;
      r.own   = $urandom;
      if (pick < 3) begin
         r.kind = REQ_CLEAR;
      end else if (pick >= 8 && have_base) begin
         lo = (cfg_min == 0) ? 1 : int'(cfg_min);
         hi = int'(cfg_max);
         pick = $urandom_range(0, 99);
         if (lo > hi) span = lo + $urandom_range(0, 50);
         else if (pick < 8) span = $urandom_range(0, lo - 1);
         else if (pick < 14) span = hi + $urandom_range(1, 100);
         else span = $urandom_range(lo, hi);
         act_d = ($urandom_range(0, 19) == 0) ? $urandom
                                              : TICK_W'((span * $urandom_range(0, 115)) / 100);
         own_d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1 << 20)
                                             : $urandom_range(0, 50);
         r.now   = base_tick + TICK_W'(span);
         r.total = base_total + act_d + own_d;
         r.own   = base_own + own_d;
         pick = $urandom_range(0, 99);
         if (pick < 4) r.total = base_total - 1 - $urandom_range(0, 100);
         else if (pick < 7) r.own = base_own - 1 - $urandom_range(0, 100);
         else if (pick < 10) r.own = base_own + act_d + own_d + 1 + $urandom_range(0, 100);
         else if (pick < 13) r.now = base_tick - 1 - $urandom_range(0, 100);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      if (mismatches <= 100)
         $display("response %0d: %s got %0h expected %0h", rsp_count, what, got, want);
   endtask

   task automatic send_sample(sample_req_type r, bit typed, meter_reading_type want);
      meter_reading_type pred;
      int gap;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= r.kind;
      req_now_tick     <= r.now;
      req_total_active <= r.total;
      req_self_active  <= r.own;
      do @(posedge clock); while (!req_ready);
      pred = predict_reading(r);
      expected_readings.push_back(typed ? want : pred);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MIN_WINDOW:  cfg_min = TICK_W'(val);
         CSR_MAX_WINDOW:  cfg_max = TICK_W'(val);
         CSR_PEAK_MARGIN: cfg_margin = val[MARGIN_W-1:0];
         default: ;
      endcase
   endtask

   function automatic stim_row_type smp_row(logic kind, logic [TICK_W-1:0] now,
                                            logic [TICK_W-1:0] total, logic [TICK_W-1:0] own,
                                            bit typed = 1'b0, meter_reading_type want = '0);
      stim_row_type row;
      row.is_cfg = 1'b0;
      row.reg_idx = '0;
      row.reg_val = '0;
      row.smp = '{kind, now, total, own};
      row.typed = typed;
      row.want = want;
      return row;
   endfunction

   function automatic stim_row_type cfg_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] val);
      stim_row_type row;
      row = smp_row(REQ_SAMPLE, 0, 0, 0);
      row.is_cfg = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      return row;
   endfunction

   initial begin : response_side
      meter_reading_type got, want;
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         rsp_count++;
         got = '{rsp_status, rsp_instant_percent, rsp_smoothed_percent, rsp_peak_percent,
                 rsp_active_delta, rsp_window_delta, rsp_primed};
         if (expected_readings.size() == 0) begin
            report_mismatch("unrequested response, status", got.status, 0);
         end else begin
            want = expected_readings.pop_front();
            if (got.status !== want.status)     report_mismatch("status", got.status, want.status);
            if (got.instant !== want.instant)   report_mismatch("instant", got.instant, want.instant);
            if (got.smoothed !== want.smoothed)
               report_mismatch("smoothed", got.smoothed, want.smoothed);
            if (got.peak !== want.peak)         report_mismatch("peak", got.peak, want.peak);
            if (got.active !== want.active)     report_mismatch("active", got.active, want.active);
            if (got.window !== want.window)     report_mismatch("window", got.window, want.window);
            if (got.primed !== want.primed)     report_mismatch("primed", got.primed, want.primed);
         end
      end
   end

   initial begin : stimulus
      stim_row_type plan[$];
      int min_set[PHASES]    = '{30, 1, 1,     0,   100, 65535, 0, 0};
      int max_set[PHASES]    = '{60, 1, 65535, 200, 50,  65535, 0, 0};
      int margin_set[PHASES] = '{3,  0, 100,   50,  10,  0,     0, 0};
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_type         <= REQ_SAMPLE;
      req_now_tick     <= '0;
      req_total_active <= '0;
      req_self_active  <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_MIN_WINDOW;
      csr_data         <= '0;
      cfg_min    = TICK_W'(MIN_WINDOW_RST);
      cfg_max    = TICK_W'(MAX_WINDOW_RST);
      cfg_margin = PEAK_MARGIN_RST;
      clear_stats();

      plan.push_back(smp_row(REQ_SAMPLE, 0, 0, 0, 1, '{STATUS_PRIMED, 0, 0, 0, 0, 0, 1}));
      plan.push_back(smp_row(REQ_SAMPLE, 10, 0, 0, 1, '{STATUS_TOO_SHORT, 0, 0, 0, 0, 0, 1}));
      plan.push_back(smp_row(REQ_SAMPLE, 40, 40, 0, 1,
                             '{STATUS_MEASURED, 100, 100, 100, 40, 40, 1}));
      plan.push_back(smp_row(REQ_SAMPLE, 100, 50, 5));
      plan.push_back(smp_row(REQ_SAMPLE, 99, 60, 5));      // time backward
      plan.push_back(smp_row(REQ_SAMPLE, 200, 70, 5));     // window too long
      plan.push_back(smp_row(REQ_SAMPLE, 230, 69, 5));     // total decreased
      plan.push_back(smp_row(REQ_SAMPLE, 260, 100, 4));    // self decreased
      plan.push_back(smp_row(REQ_SAMPLE, 290, 110, 20));   // self delta above total delta
      plan.push_back(smp_row(REQ_SAMPLE, 320, 130, 20));   // window exactly at minimum
      plan.push_back(smp_row(REQ_CLEAR, 320, 130, 20, 1, '{STATUS_CLEARED, 0, 0, 0, 0, 0, 0}));
      plan.push_back(smp_row(REQ_SAMPLE, '1, '1, '1, 1, '{STATUS_PRIMED, 0, 0, 0, 0, 0, 1}));
      plan.push_back(smp_row(REQ_SAMPLE, 0, 0, 0));
      plan.push_back(cfg_row(CSR_MIN_WINDOW, 0));
      plan.push_back(cfg_row(CSR_MAX_WINDOW, 16'hFFFF));
      plan.push_back(cfg_row(CSR_PEAK_MARGIN, 0));
      plan.push_back(cfg_row(CSR_SPARE, 16'hFFFF));
      plan.push_back(smp_row(REQ_SAMPLE, 0, 5, 0));        // zero-length window
      plan.push_back(smp_row(REQ_SAMPLE, 65535, '1, 0));   // saturates at 100
      plan.push_back(smp_row(REQ_SAMPLE, 65536, '1, 0));
      plan.push_back(smp_row(REQ_SAMPLE, 65537, '1, 0));   // peak decays
      plan.push_back(cfg_row(CSR_MIN_WINDOW, 16'hFFFF));
      plan.push_back(cfg_row(CSR_MAX_WINDOW, 1));
      plan.push_back(cfg_row(CSR_PEAK_MARGIN, 100));
      plan.push_back(smp_row(REQ_SAMPLE, 131072, '1, 0));  // min above max
      plan.push_back(smp_row(REQ_SAMPLE, 131073, '1, 0));
      plan.push_back(smp_row(REQ_CLEAR, '1, '1, '1, 1, '{STATUS_CLEARED, 0, 0, 0, 0, 0, 0}));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_cfg) write_reg(plan[i].reg_idx, plan[i].reg_val);
         else send_sample(plan[i].smp, plan[i].typed, plan[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p >= 6) begin
            min_set[p]    = $urandom_range(1, 200);
            max_set[p]    = min_set[p] + $urandom_range(0, 2000);
            margin_set[p] = $urandom_range(0, 100);
         end
         write_reg(CSR_MIN_WINDOW, CSR_DATA_W'(min_set[p]));
         write_reg(CSR_MAX_WINDOW, CSR_DATA_W'(max_set[p]));
         write_reg(CSR_PEAK_MARGIN, CSR_DATA_W'(margin_set[p]));
         calm = (p % 4 == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) send_sample(make_sample(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
design/um_pkg.sv
design/um_div.sv
design/utilization_meter_unit.sv
design/um_checker.sv
dv/tb_utilization_meter_unit.sv
